// File: sv/hdlc_frame_builder_crc16_defines.svh
// Assertion macros shared by the frame builder RTL.
`ifndef HDLC_FRAME_BUILDER_CRC16_DEFINES_SVH
`define HDLC_FRAME_BUILDER_CRC16_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a property holds at every clock edge outside reset.
`define HFB_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("hfb assertion failed");

// Check that a condition never holds at a clock edge outside reset.
`define HFB_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("hfb forbidden condition seen");

`else

`define HFB_ASSERT(label, clk, rst_n, prop)
`define HFB_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: sv/hfb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hfb_pkg;

	// Framing and check constants
	localparam logic [7:0]  FLAG_BYTE    = 8'h7E;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'h8408;
	localparam logic [15:0] FMT_TYPE3    = 16'hA000;
	localparam logic [10:0] LEN_MASK     = 11'h7FF;
	localparam logic [10:0] LEN_OVERHEAD = 11'd10;

	// Largest number of words one input word can cause
	localparam int BURST_MAX = 12;
	localparam int IDX_W     = $clog2(BURST_MAX);

	typedef enum logic {
		OP_START = 1'b0,
		OP_DATA  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_DEST_LOGICAL  = 2'd0,
		REG_DEST_PHYSICAL = 2'd1,
		REG_SOURCE        = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] dest_logical;
		logic [7:0] dest_physical;
		logic [7:0] source;
	} cfg_t;

	// Input word after the header stage
	typedef struct packed {
		op_t         op;
		logic [10:0] plen;
		logic [7:0]  ctrl;
		logic [15:0] fmt;
		logic [15:0] crc6;
		logic [7:0]  data;
	} hdr_item_t;

	// Group of output words caused by one input word
	typedef struct packed {
		logic [BURST_MAX-1:0][7:0] bytes;
		logic [IDX_W-1:0]          last_idx;
		logic                      closes;
	} burst_t;

	// One byte of CRC-16/X.25, reflected, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: sv/hfb_hdr_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module hfb_hdr_stage
	import hfb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cfg_t        cfg,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire op_t         in_op,
	input  wire logic [10:0] in_plen,
	input  wire logic [7:0]  in_ctrl,
	input  wire logic        in_seg,
	input  wire logic [7:0]  in_data,
	output logic             valid_s1,
	input  wire logic        take,
	output hdr_item_t        item_s1
);

	logic [10:0] len_word;
	logic [15:0] fmt;
	logic [15:0] crc6;

	// Build the format word and run the header check over its six bytes
	always_comb begin
		len_word = 11'(in_plen + LEN_OVERHEAD) & LEN_MASK;
		fmt      = FMT_TYPE3 | {4'b0000, in_seg, 11'd0} | {5'd0, len_word};
		crc6     = crc_byte(CRC_INIT, fmt[15:8]);
		crc6     = crc_byte(crc6, fmt[7:0]);
		crc6     = crc_byte(crc6, cfg.dest_logical);
		crc6     = crc_byte(crc6, cfg.dest_physical);
		crc6     = crc_byte(crc6, cfg.source);
		crc6     = crc_byte(crc6, in_ctrl);
	end

	assign in_ready = !valid_s1 || take;

	// Hold the word until the frame stage takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.op   <= in_op;
			item_s1.plen <= in_plen;
			item_s1.ctrl <= in_ctrl;
			item_s1.fmt  <= fmt;
			item_s1.crc6 <= crc6;
			item_s1.data <= in_data;
		end
	end

endmodule

`default_nettype wire

// File: sv/hfb_frame_state.sv
`timescale 1ns / 1ps
`default_nettype none

`include "hdlc_frame_builder_crc16_defines.svh"

module hfb_frame_state
	import hfb_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cfg_t      cfg,
	input  wire logic      valid_s1,
	input  wire hdr_item_t item_s1,
	output logic           take,
	input  wire logic      burst_free,
	output logic           burst_load,
	output burst_t         burst
);

	logic [15:0] crc_q;
	logic [10:0] bytes_left_q;
	logic        frame_open_q;

	logic        stray;
	logic        closes;
	logic [15:0] hcs;
	logic [15:0] crc7;
	logic [15:0] crc8;
	logic [15:0] crc_pay;
	logic [10:0] bl_dec;
	logic [15:0] fcs;

	// Drop a payload word that arrives with no frame open
	assign stray      = (item_s1.op == OP_DATA) && !frame_open_q;
	assign take       = valid_s1 && (stray || burst_free);
	assign burst_load = valid_s1 && !stray && burst_free;

	// Finish the header check and advance the frame check
	always_comb begin
		hcs     = ~item_s1.crc6;
		crc7    = crc_byte(item_s1.crc6, hcs[7:0]);
		crc8    = crc_byte(crc7, hcs[15:8]);
		crc_pay = crc_byte(crc_q, item_s1.data);
		bl_dec  = bytes_left_q - 11'd1;
	end

	// Lay out the words for the serializer
	always_comb begin
		burst.bytes = '0;
		unique case (item_s1.op)
			OP_START: begin
				closes          = (item_s1.plen == 11'd0);
				fcs             = ~crc8;
				burst.bytes[0]  = FLAG_BYTE;
				burst.bytes[1]  = item_s1.fmt[15:8];
				burst.bytes[2]  = item_s1.fmt[7:0];
				burst.bytes[3]  = cfg.dest_logical;
				burst.bytes[4]  = cfg.dest_physical;
				burst.bytes[5]  = cfg.source;
				burst.bytes[6]  = item_s1.ctrl;
				burst.bytes[7]  = hcs[7:0];
				burst.bytes[8]  = hcs[15:8];
				burst.bytes[9]  = fcs[7:0];
				burst.bytes[10] = fcs[15:8];
				burst.bytes[11] = FLAG_BYTE;
				burst.last_idx  = closes ? IDX_W'(11) : IDX_W'(8);
			end
			OP_DATA: begin
				closes         = (bl_dec == 11'd0);
				fcs            = ~crc_pay;
				burst.bytes[0] = item_s1.data;
				burst.bytes[1] = fcs[7:0];
				burst.bytes[2] = fcs[15:8];
				burst.bytes[3] = FLAG_BYTE;
				burst.last_idx = closes ? IDX_W'(3) : IDX_W'(0);
			end
			default: begin
				closes         = 1'b0;
				fcs            = '0;
				burst.last_idx = '0;
			end
		endcase
		burst.closes = closes;
	end

	// Update the frame state on each word handed on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q        <= CRC_INIT;
			bytes_left_q <= '0;
			frame_open_q <= 1'b0;
		end else if (burst_load) begin
			if (closes) begin
				crc_q        <= CRC_INIT;
				bytes_left_q <= '0;
				frame_open_q <= 1'b0;
			end else if (item_s1.op == OP_START) begin
				crc_q        <= crc8;
				bytes_left_q <= item_s1.plen;
				frame_open_q <= 1'b1;
			end else begin
				crc_q        <= crc_pay;
				bytes_left_q <= bl_dec;
			end
		end
	end

	`HFB_ASSERT(a_open_has_count, clk, arst_n, frame_open_q |-> (bytes_left_q != 11'd0))
	`HFB_ASSERT(a_closed_crc_init, clk, arst_n, !frame_open_q |-> (crc_q == CRC_INIT))
	`HFB_NEVER(a_stray_loads, clk, arst_n, burst_load && stray)

endmodule

`default_nettype wire

// File: sv/hfb_serializer.sv
`timescale 1ns / 1ps
`default_nettype none

`include "hdlc_frame_builder_crc16_defines.svh"

module hfb_serializer
	import hfb_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   burst_load,
	input  wire burst_t burst,
	output logic        burst_free,
	output logic        m_tvalid,
	input  wire logic   m_tready,
	output logic [7:0]  m_tdata,
	output logic        m_tlast,
	output logic        m_tuser
);

	burst_t           burst_q;
	logic             bv_q;
	logic [IDX_W-1:0] idx_q;
	logic             at_last;

	assign at_last    = (idx_q == burst_q.last_idx);
	assign burst_free = !bv_q || (m_tready && at_last);

	assign m_tvalid = bv_q;
	assign m_tdata  = burst_q.bytes[idx_q];
	assign m_tlast  = at_last;
	assign m_tuser  = at_last && burst_q.closes;

	// Step through the held words, load the next group behind the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bv_q  <= 1'b0;
			idx_q <= '0;
		end else if (burst_load) begin
			bv_q  <= 1'b1;
			idx_q <= '0;
		end else if (bv_q && m_tready) begin
			if (at_last) begin
				bv_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (burst_load) begin
			burst_q <= burst;
		end
	end

	`HFB_ASSERT(a_idx_in_range, clk, arst_n, bv_q |-> (idx_q <= burst_q.last_idx))
	`HFB_ASSERT(a_done_is_flag, clk, arst_n, (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == FLAG_BYTE)))
	`HFB_ASSERT(a_drain_empties, clk, arst_n, (bv_q && m_tready && at_last && !burst_load) |=> !bv_q)

endmodule

`default_nettype wire

// File: sv/hdlc_frame_builder_crc16.sv
`timescale 1ns / 1ps
`default_nettype none

// The first output word of an input word shows once the word has passed the header register and
// been loaded into the serializer register. Throughput: one payload word per cycle while m_tready
// is high; a start word gives 9 output words, 12 when the payload is empty, and the closing payload
// word 4 (data, FCS and flag). The output serializer, one word per ready cycle, sets these figures.
// Reset: arst_n clears the address registers to 0, the check to 0xFFFF, closes any frame.

module hdlc_frame_builder_crc16
	import hfb_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,  // payload_length[10:0], control_byte[18:11], segmented[19], data_byte[27:20]
	input  wire logic [0:0]  s_tuser,  // op[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,  // out_byte[7:0]
	output logic             m_tlast,
	output logic [0:0]       m_tuser,  // frame_done[0]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_addr,
	input  wire logic [7:0]  cfg_data
);

	cfg_t      cfg_q;
	logic      valid_s1;
	logic      take;
	hdr_item_t item_s1;
	logic      burst_free;
	logic      burst_load;
	burst_t    burst;
	logic      frame_done;

	// Address registers, writes past the list are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_addr)
				REG_DEST_LOGICAL:  cfg_q.dest_logical  <= cfg_data;
				REG_DEST_PHYSICAL: cfg_q.dest_physical <= cfg_data;
				REG_SOURCE:        cfg_q.source        <= cfg_data;
				default: ;
			endcase
		end
	end

	hfb_hdr_stage u_hdr (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (op_t'(s_tuser[0])),
		.in_plen  (s_tdata[10:0]),
		.in_ctrl  (s_tdata[18:11]),
		.in_seg   (s_tdata[19]),
		.in_data  (s_tdata[27:20]),
		.valid_s1 (valid_s1),
		.take     (take),
		.item_s1  (item_s1)
	);

	hfb_frame_state u_state (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.take       (take),
		.burst_free (burst_free),
		.burst_load (burst_load),
		.burst      (burst)
	);

	hfb_serializer u_ser (
		.clk        (clk),
		.arst_n     (arst_n),
		.burst_load (burst_load),
		.burst      (burst),
		.burst_free (burst_free),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (frame_done)
	);

	assign m_tuser = frame_done;

endmodule

`default_nettype wire

// File: bench/tb_hdlc_frame_builder_crc16.sv
`timescale 1ns / 1ps

module tb_hdlc_frame_builder_crc16;
	import hfb_pkg::*;

	localparam int         SETTLE_CYCLES = 16;
	localparam logic [6:0] STALL_PCT     = 7'd23;
	localparam int         RAND_WORDS    = 440;
	localparam int         PHASES        = 5;
	// Index past the register list; writes to it must change nothing
	localparam logic [1:0] REG_SPARE     = 2'd3;

	typedef enum logic [1:0] {
		CMD_WORD,
		CMD_CFG,
		CMD_DRAIN
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		op_t         op;
		logic [10:0] plen;
		logic [7:0]  ctrl;
		logic        seg;
		logic [7:0]  data;
		logic [1:0]  addr;
		logic [7:0]  value;
		logic [6:0]  gap_pct;
	} cmd_t;

	typedef struct packed {
		logic [7:0] octet;
		logic       last;
		logic       done;
	} framed_octet_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_addr = '0;
	logic [7:0]  cfg_data = '0;

	cmd_t          cmd_q[$];
	framed_octet_t octet_q[$];
	cmd_t          cur_word;
	logic [6:0]    stall_pct = STALL_PCT;
	int            hold_cnt = 0;
	int            err_cnt = 0;

	// Frame builder mirror: address registers and open-frame state
	logic [7:0]  addr_logical = '0;
	logic [7:0]  addr_physical = '0;
	logic [7:0]  addr_source = '0;
	logic [15:0] fcs_run = CRC_INIT;
	logic [10:0] bytes_due = '0;
	logic        in_frame = 1'b0;

	// Stimulus generator state
	int   gen_count;
	logic gen_open;

	hdlc_frame_builder_crc16 dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// CRC-16/X.25, one bit at a time, LSB of the byte first
	function automatic logic [15:0] x25_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb)
				c = c ^ CRC_POLY;
		end
		return c;
	endfunction

	task automatic push_octet(input logic [7:0] b, input logic last, input logic done);
		framed_octet_t e;
		e.octet = b;
		e.last = last;
		e.done = done;
		octet_q = {octet_q, e};
	endtask

	// Append a command at the tail of the command queue
	task automatic enqueue_cmd(input cmd_t c);
		cmd_q = {cmd_q, c};
	endtask

	// Emit FCS and closing flag, then return to the idle state
	task automatic close_frame();
		logic [15:0] fcs;
		fcs = ~fcs_run;
		push_octet(fcs[7:0], 1'b0, 1'b0);
		push_octet(fcs[15:8], 1'b0, 1'b0);
		push_octet(FLAG_BYTE, 1'b1, 1'b1);
		in_frame = 1'b0;
		bytes_due = '0;
		fcs_run = CRC_INIT;
	endtask

	// Work out the framed bytes that one accepted input word causes
	task automatic frame_predict(input cmd_t w);
		logic [10:0] len_field;
		logic [15:0] fmt;
		logic [15:0] crc;
		logic [15:0] hcs;
		logic [7:0]  hdr[6];
		if (w.op == OP_START) begin
			len_field = w.plen + LEN_OVERHEAD;
			fmt = FMT_TYPE3 | {4'b0000, w.seg, len_field};
			hdr[0] = fmt[15:8];
			hdr[1] = fmt[7:0];
			hdr[2] = addr_logical;
			hdr[3] = addr_physical;
			hdr[4] = addr_source;
			hdr[5] = w.ctrl;
			crc = CRC_INIT;
			push_octet(FLAG_BYTE, 1'b0, 1'b0);
			for (int i = 0; i < 6; i++) begin
				crc = x25_update(crc, hdr[i]);
				push_octet(hdr[i], 1'b0, 1'b0);
			end
			hcs = ~crc;
			crc = x25_update(crc, hcs[7:0]);
			push_octet(hcs[7:0], 1'b0, 1'b0);
			crc = x25_update(crc, hcs[15:8]);
			push_octet(hcs[15:8], w.plen != 0, 1'b0);
			fcs_run = crc;
			bytes_due = w.plen;
			in_frame = 1'b1;
			if (w.plen == 0)
				close_frame();
		end else if (in_frame) begin
			fcs_run = x25_update(fcs_run, w.data);
			bytes_due = bytes_due - 11'd1;
			push_octet(w.data, bytes_due != 0, 1'b0);
			if (bytes_due == 0)
				close_frame();
		end
	endtask

	task automatic cfg_apply(input logic [1:0] idx, input logic [7:0] v);
		case (idx)
			REG_DEST_LOGICAL:  addr_logical = v;
			REG_DEST_PHYSICAL: addr_physical = v;
			REG_SOURCE:        addr_source = v;
			default: ;
		endcase
	endtask

	task automatic add_start(input logic [10:0] plen, input logic [7:0] ctrl, input logic seg,
			input logic [6:0] pct);
		cmd_t c;
		c = '0;
		c.kind = CMD_WORD;
		c.op = OP_START;
		c.plen = plen;
		c.ctrl = ctrl;
		c.seg = seg;
		c.data = 8'($urandom);
		c.gap_pct = pct;
		enqueue_cmd(c);
	endtask

	// Payload word; the start-only fields carry noise the block must ignore
	task automatic add_data(input logic [7:0] data, input logic [6:0] pct);
		cmd_t c;
		c = '0;
		c.kind = CMD_WORD;
		c.op = OP_DATA;
		c.plen = 11'($urandom);
		c.ctrl = 8'($urandom);
		c.seg = 1'($urandom);
		c.data = data;
		c.gap_pct = pct;
		enqueue_cmd(c);
	endtask

	task automatic add_cfg(input logic [1:0] idx, input logic [7:0] v);
		cmd_t c;
		c = '0;
		c.kind = CMD_CFG;
		c.addr = idx;
		c.value = v;
		enqueue_cmd(c);
	endtask

	task automatic add_drain();
		cmd_t c;
		c = '0;
		c.kind = CMD_DRAIN;
		enqueue_cmd(c);
	endtask

	// One random frame: mostly well formed, some cut short, some stray bytes
	task automatic gen_frame(input logic [6:0] pct);
		int pick;
		int plen;
		int cut;
		int n_stray;
		pick = $urandom_range(99);
		if (pick < 10 && !gen_open) begin
			n_stray = $urandom_range(3, 1);
			repeat (n_stray)
				add_data(8'($urandom), pct);
			gen_count += n_stray;
		end else if (pick < 22) begin
			plen = $urandom_range(2047, 1);
			cut = $urandom_range(plen < 7 ? plen - 1 : 6, 0);
			add_start(11'(plen), 8'($urandom), 1'($urandom), pct);
			repeat (cut)
				add_data(8'($urandom), pct);
			gen_count += 1 + cut;
			gen_open = 1'b1;
		end else begin
			pick = $urandom_range(99);
			if (pick < 85)
				plen = $urandom_range(12, 0);
			else if (pick < 97)
				plen = $urandom_range(64, 13);
			else
				plen = $urandom_range(200, 65);
			add_start(11'(plen), 8'($urandom), 1'($urandom), pct);
			repeat (plen)
				add_data(8'($urandom), pct);
			gen_count += 1 + plen;
			gen_open = 1'b0;
		end
	endtask

	// Sender: feed words and register writes from the command queue
	always @(posedge clk) begin : drive_words
		cmd_t head;
		logic next_s;
		logic next_c;
		if (arst_n) begin
			next_s = s_tvalid && !s_tready;
			next_c = cfg_valid && !cfg_ready;
			if (s_tvalid && s_tready)
				frame_predict(cur_word);
			if (cfg_valid && cfg_ready)
				cfg_apply(cfg_addr, cfg_data);
			if (!next_s && !next_c && cmd_q.size() > 0) begin
				head = cmd_q[0];
				if (hold_cnt > 0) begin
					hold_cnt = hold_cnt - 1;
				end else begin
					case (head.kind)
						CMD_WORD: begin
							if ($urandom_range(99) >= head.gap_pct) begin
								void'(cmd_q.pop_front());
								s_tdata <= {4'b0000, head.data, head.seg, head.ctrl, head.plen};
								s_tuser <= head.op;
								cur_word <= head;
								stall_pct <= head.gap_pct;
								next_s = 1'b1;
							end
						end
						CMD_CFG: begin
							void'(cmd_q.pop_front());
							cfg_addr <= head.addr;
							cfg_data <= head.value;
							next_c = 1'b1;
						end
						default: begin
							// Hold off until every framed byte is out, then let the block settle
							if (octet_q.size() == 0) begin
								void'(cmd_q.pop_front());
								hold_cnt = SETTLE_CYCLES;
							end
						end
					endcase
				end
			end
			s_tvalid <= next_s;
			cfg_valid <= next_c;
		end
	end

	// Receiver: random backpressure and field-by-field compare
	always @(posedge clk) begin : watch_output
		framed_octet_t want;
		if (arst_n) begin
			m_tready <= ($urandom_range(99) >= stall_pct);
			if (m_tvalid && m_tready) begin
				if (octet_q.size() == 0) begin
					err_cnt++;
					$display("%0t ns: unexpected word: expected none, got byte %02h last %b done %b",
						$time, m_tdata, m_tlast, m_tuser[0]);
				end else begin
					want = octet_q.pop_front();
					if (m_tdata !== want.octet) begin
						err_cnt++;
						$display("%0t ns: out_byte expected %02h, got %02h",
							$time, want.octet, m_tdata);
					end
					if (m_tlast !== want.last) begin
						err_cnt++;
						$display("%0t ns: last_of_run expected %b, got %b",
							$time, want.last, m_tlast);
					end
					if (m_tuser[0] !== want.done) begin
						err_cnt++;
						$display("%0t ns: frame_done expected %b, got %b",
							$time, want.done, m_tuser[0]);
					end
				end
			end
		end
	end

	initial begin
		// Directed: empty payload, field extremes, length wrap, stray bytes, abandoned frames
		add_start(11'd0, 8'hFF, 1'b1, STALL_PCT);
		add_data(8'h00, STALL_PCT);
		add_start(11'd2, 8'h00, 1'b0, STALL_PCT);
		add_data(8'hFF, STALL_PCT);
		add_data(8'h00, STALL_PCT);
		add_start(11'd2047, 8'hA5, 1'b1, STALL_PCT);
		add_data(8'h5A, STALL_PCT);
		add_start(11'd1, 8'h3C, 1'b0, STALL_PCT);
		add_data(8'h81, STALL_PCT);
		add_start(11'd2037, 8'h13, 1'b0, STALL_PCT);
		add_data(8'hC3, STALL_PCT);
		add_start(11'd2038, 8'h7E, 1'b1, STALL_PCT);
		add_start(11'd0, 8'h01, 1'b0, STALL_PCT);
		add_data(8'hFF, STALL_PCT);

		// Top addresses, plus a write to the spare index that must be dropped
		add_drain();
		add_cfg(REG_DEST_LOGICAL, 8'hFF);
		add_cfg(REG_DEST_PHYSICAL, 8'hFF);
		add_cfg(REG_SOURCE, 8'hFF);
		add_cfg(REG_SPARE, 8'h5A);
		add_start(11'd3, 8'h55, 1'b1, STALL_PCT);
		add_data(8'h7E, STALL_PCT);
		add_data(8'h80, STALL_PCT);
		add_data(8'h01, STALL_PCT);

		// Random phases, each under its own address setting; phase 2 runs without idling
		gen_count = 0;
		gen_open = 1'b0;
		for (int p = 0; p < PHASES; p++) begin
			add_drain();
			add_cfg(REG_DEST_LOGICAL, p == 1 ? 8'h00 : p == 4 ? 8'hFF : 8'($urandom));
			add_cfg(REG_DEST_PHYSICAL, p == 1 ? 8'h00 : p == 4 ? 8'hFF : 8'($urandom));
			add_cfg(REG_SOURCE, p == 1 ? 8'h00 : p == 4 ? 8'hFF : 8'($urandom));
			while (gen_count < RAND_WORDS * (p + 1) / PHASES)
				gen_frame(p == 2 ? 7'd0 : STALL_PCT);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_q.size() != 0 || s_tvalid || cfg_valid || octet_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (octet_q.size() != 0) begin
			err_cnt += octet_q.size();
			$display("%0t ns: %0d words never arrived, first expected byte %02h, got none",
				$time, octet_q.size(), octet_q[0].octet);
		end
		if (err_cnt == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// File: hdlc_frame_builder_crc16.f
+incdir+sv
sv/hfb_pkg.sv
sv/hfb_hdr_stage.sv
sv/hfb_frame_state.sv
sv/hfb_serializer.sv
sv/hdlc_frame_builder_crc16.sv
bench/tb_hdlc_frame_builder_crc16.sv
